// ===== src/ttt_pkg.sv =====
// shared types and codes for the timed ticket table
// no dependencies
package ttt_pkg;

  // command codes
  localparam logic [2:0] CMD_ISSUE    = 3'd0;
  localparam logic [2:0] CMD_REMEMBER = 3'd1;
  localparam logic [2:0] CMD_GET      = 3'd2;
  localparam logic [2:0] CMD_LIST     = 3'd3;
  localparam logic [2:0] CMD_MARK     = 3'd4;
  localparam logic [2:0] CMD_CLEANUP  = 3'd5;

  // entry kinds
  localparam logic [1:0] KIND_OUT  = 2'd1;
  localparam logic [1:0] KIND_IN   = 2'd2;
  localparam logic [1:0] KIND_LAST = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  // configuration register indexes
  localparam logic [7:0] REG_DELIVERY = 8'd0;
  localparam logic [7:0] REG_RENEW    = 8'd1;
  localparam logic [7:0] REG_EXPIRY   = 8'd2;
  localparam logic [7:0] REG_GRACE    = 8'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] peer_high;
    logic [63:0] peer_low;
    logic [63:0] time_val;
    logic [63:0] ticket_high;
    logic [63:0] ticket_low;
  } slot_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_PRECHK,
    S_READ,
    S_LOOK,
    S_CHK1,
    S_CHK2,
    S_NEXT,
    S_FINAL,
    S_ADDCHK,
    S_EMIT
  } state_t;

endpackage

// ===== src/ttt_alu.sv =====
// shared 64-bit add/subtract unit with registered result and carry
// depends on ttt_pkg
module ttt_alu (
  input  logic             clk,
  input  ttt_pkg::alu_op_t op,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic [63:0]      res,
  output logic             cy
);
  import ttt_pkg::*;

  logic [64:0] sum;

  // carry for add, borrow for subtract
  always_comb begin
    unique case (op)
      ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default: sum = {1'b0, a} - {1'b0, b};
    endcase
  end

  always_ff @(posedge clk) begin
    res <= sum[63:0];
    cy  <= sum[64];
  end

endmodule

// ===== src/ttt_table.sv =====
// entry storage: one write port, one registered read port
// depends on ttt_pkg
module ttt_table #(
  parameter int ENTRIES = 16,
  parameter int IW = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  ttt_pkg::slot_t  wdata,
  input  logic [IW-1:0]   raddr,
  output ttt_pkg::slot_t  rdata
);
  import ttt_pkg::*;

  slot_t mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/timed_ticket_table_unit.sv =====
// timed ticket table: top level with command sequencer
// depends on ttt_pkg, ttt_alu, ttt_table
//
// channel  | handshake             | content
// ---------+-----------------------+----------------------------------------
// in       | in_valid / in_ready   | cmd, peer, now, ticket, outbound_expiry, limit
// out      | out_valid / out_ready | status, created, expiry_time, ticket, last, entries_used
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// a command walks the table one entry at a time: an entry that does not match
// passes read, look and next; a matching entry may add check states. the walk
// is paced by the single table read port and the shared add/subtract unit, and
// a final state finishes the walk. list gives one word per live ticket, up to
// limit, then a last word. reset empties the table at once (fill count only).
// in_ready is low from acceptance until the last result word is taken.
module timed_ticket_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [63:0] peer_high,
  input  logic [63:0] peer_low,
  input  logic [63:0] now,
  input  logic [63:0] ticket_high,
  input  logic [63:0] ticket_low,
  input  logic [63:0] outbound_expiry,
  input  logic [4:0]  limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        created,
  output logic [63:0] expiry_time,
  output logic [63:0] out_ticket_high,
  output logic [63:0] out_ticket_low,
  output logic        last,
  output logic [4:0]  entries_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ttt_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t state, state_next;

  // configuration registers
  logic [31:0] delivery_interval, renew_margin, expiry_span, grace_span;

  // latched command word
  logic [2:0]  cmd_q;
  logic [63:0] ph, pl, now_q, th, tl, exp_q;
  logic [4:0]  lim;

  // scan state
  logic [CW-1:0] idx, wp, fill, n;
  logic          last_seen, in_hit, resume;
  logic [63:0]   hit_time, hit_th, hit_tl;

  // unit and table hookup
  alu_op_t     u_op;
  logic [63:0] u_a, u_b, u_res;
  logic        u_cy;
  logic        we, keep;
  logic [IW-1:0] waddr;
  slot_t       wdata, rd, new_slot;

  // control decisions
  logic          emit, e_created, e_last;
  logic [1:0]    e_status;
  logic [63:0]   e_time, e_th, e_tl;
  logic [CW-1:0] fill_next;
  logic          set_last_seen, set_in_hit, n_inc, wp_inc;
  logic          mk_last, mk_in, mk_out, peer_eq, full;

  ttt_alu u_alu (
    .clk(clk), .op(u_op), .a(u_a), .b(u_b), .res(u_res), .cy(u_cy)
  );

  ttt_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(idx[IW-1:0]), .rdata(rd)
  );

  // entry match against the latched peer
  assign peer_eq = (rd.peer_high == ph) && (rd.peer_low == pl);
  assign mk_last = peer_eq && (rd.kind == KIND_LAST);
  assign mk_in   = peer_eq && (rd.kind == KIND_IN);
  assign mk_out  = peer_eq && (rd.kind == KIND_OUT);
  assign full    = (fill >= CW'(ENTRIES));

  // replacement or appended entry for remember and mark delivered
  always_comb begin
    new_slot.peer_high = ph;
    new_slot.peer_low  = pl;
    if (cmd_q == CMD_REMEMBER) begin
      new_slot.kind        = KIND_OUT;
      new_slot.time_val    = exp_q;
      new_slot.ticket_high = th;
      new_slot.ticket_low  = tl;
    end else begin
      new_slot.kind        = KIND_LAST;
      new_slot.time_val    = now_q;
      new_slot.ticket_high = '0;
      new_slot.ticket_low  = '0;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_REMEMBER) state_next = S_PRE;
          else if (cmd <= CMD_CLEANUP) state_next = S_READ;
          else state_next = S_FINAL;
        end
      end
      S_PRE: state_next = S_PRECHK;
      S_PRECHK: state_next = u_cy ? S_READ : S_EMIT;
      S_READ: state_next = (idx == fill) ? S_FINAL : S_LOOK;
      S_LOOK: begin
        state_next = S_NEXT;
        unique case (cmd_q)
          CMD_ISSUE: if ((mk_last && !last_seen) || (mk_in && !in_hit)) state_next = S_CHK1;
          CMD_REMEMBER: if (mk_out) state_next = S_EMIT;
          CMD_MARK: if (mk_last) state_next = S_EMIT;
          CMD_GET: if (mk_out) state_next = S_CHK1;
          CMD_LIST: if (mk_in) state_next = S_CHK1;
          CMD_CLEANUP: begin
            if (rd.kind == KIND_OUT || rd.kind == KIND_IN) state_next = S_CHK1;
          end
          default: state_next = S_NEXT;
        endcase
      end
      S_CHK1: begin
        state_next = S_NEXT;
        unique case (cmd_q)
          CMD_ISSUE: begin
            if (mk_last) state_next = u_cy ? S_EMIT : S_CHK2;
            else if (!(u_cy || u_res == '0)) state_next = S_CHK2;
          end
          CMD_GET: state_next = S_EMIT;
          CMD_LIST: if (u_cy) state_next = S_EMIT;
          CMD_CLEANUP: if (rd.kind == KIND_IN && !u_cy) state_next = S_CHK2;
          default: state_next = S_NEXT;
        endcase
      end
      S_CHK2: begin
        state_next = S_NEXT;
        if (cmd_q == CMD_ISSUE && mk_last && u_cy) state_next = S_EMIT;
      end
      S_NEXT: state_next = S_READ;
      S_FINAL: begin
        state_next = S_EMIT;
        if (cmd_q == CMD_ISSUE && !in_hit && !full) state_next = S_ADDCHK;
      end
      S_ADDCHK: state_next = S_EMIT;
      S_EMIT: if (out_ready) state_next = resume ? S_NEXT : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    u_op = ALU_SUB;
    u_a = now_q;
    u_b = rd.time_val;
    we = 1'b0;
    keep = 1'b0;
    waddr = idx[IW-1:0];
    wdata = rd;
    emit = 1'b0;
    e_status = ST_OK;
    e_created = 1'b0;
    e_time = '0;
    e_th = '0;
    e_tl = '0;
    e_last = 1'b1;
    fill_next = fill;
    set_last_seen = 1'b0;
    set_in_hit = 1'b0;
    n_inc = 1'b0;
    wp_inc = 1'b0;
    unique case (state)
      S_PRE: u_b = exp_q;
      S_PRECHK: begin
        if (!u_cy) begin
          emit = 1'b1;
          e_status = ST_BAD;
        end
      end
      S_LOOK: begin
        unique case (cmd_q)
          CMD_ISSUE: begin
            if (!mk_last) begin
              u_a = rd.time_val;
              u_b = now_q;
            end
          end
          CMD_REMEMBER, CMD_MARK: begin
            if ((cmd_q == CMD_REMEMBER) ? mk_out : mk_last) begin
              we = 1'b1;
              wdata = new_slot;
              emit = 1'b1;
            end
          end
          CMD_CLEANUP: keep = !(rd.kind == KIND_OUT || rd.kind == KIND_IN);
          default: ;
        endcase
      end
      S_CHK1: begin
        unique case (cmd_q)
          CMD_ISSUE: begin
            if (mk_last) begin
              if (u_cy) begin
                emit = 1'b1;
                e_status = ST_PENDING;
              end
              u_a = u_res;
              u_b = 64'(delivery_interval);
            end else begin
              u_a = 64'(renew_margin);
              u_b = u_res;
            end
          end
          CMD_GET: begin
            emit = 1'b1;
            if (u_cy) begin
              e_time = rd.time_val;
              e_th = rd.ticket_high;
              e_tl = rd.ticket_low;
            end else begin
              e_status = ST_PENDING;
            end
          end
          CMD_LIST: begin
            if (u_cy) begin
              emit = 1'b1;
              if (32'(n) == 32'(lim)) begin
                e_status = ST_FULL;
              end else begin
                e_time = rd.time_val;
                e_th = rd.ticket_high;
                e_tl = rd.ticket_low;
                e_last = 1'b0;
                n_inc = 1'b1;
              end
            end
          end
          CMD_CLEANUP: begin
            keep = u_cy;
            u_a = 64'(grace_span);
            u_b = u_res;
          end
          default: ;
        endcase
      end
      S_CHK2: begin
        if (cmd_q == CMD_ISSUE) begin
          if (mk_last) begin
            if (u_cy) begin
              emit = 1'b1;
              e_status = ST_PENDING;
            end else begin
              set_last_seen = 1'b1;
            end
          end else begin
            set_in_hit = u_cy;
          end
        end else if (cmd_q == CMD_CLEANUP) begin
          keep = !u_cy;
        end
      end
      S_FINAL: begin
        emit = 1'b1;
        unique case (cmd_q)
          CMD_ISSUE: begin
            if (in_hit) begin
              e_time = hit_time;
              e_th = hit_th;
              e_tl = hit_tl;
            end else if (full) begin
              e_status = ST_FULL;
            end else begin
              emit = 1'b0;
              u_op = ALU_ADD;
              u_b = 64'(expiry_span);
            end
          end
          CMD_REMEMBER, CMD_MARK: begin
            if (full) begin
              e_status = ST_FULL;
            end else begin
              we = 1'b1;
              waddr = fill[IW-1:0];
              wdata = new_slot;
              fill_next = fill + CW'(1);
            end
          end
          CMD_GET: e_status = ST_PENDING;
          CMD_LIST: ;
          CMD_CLEANUP: fill_next = wp;
          default: e_status = ST_BAD;
        endcase
      end
      S_ADDCHK: begin
        emit = 1'b1;
        if (u_cy) begin
          e_status = ST_FULL;
        end else begin
          we = 1'b1;
          waddr = fill[IW-1:0];
          wdata = '{kind: KIND_IN, peer_high: ph, peer_low: pl, time_val: u_res,
                    ticket_high: th, ticket_low: tl};
          fill_next = fill + CW'(1);
          e_created = 1'b1;
          e_time = u_res;
          e_th = th;
          e_tl = tl;
        end
      end
      default: ;
    endcase
    // survivor of cleanup slides down to the write pointer
    if (keep) begin
      wp_inc = 1'b1;
      if (wp != idx) begin
        we = 1'b1;
        waddr = wp[IW-1:0];
        wdata = rd;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      delivery_interval <= 32'd86400;
      renew_margin <= 32'd1209600;
      expiry_span <= 32'd1814400;
      grace_span <= 32'd432000;
    end else begin
      state <= state_next;
      fill <= fill_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DELIVERY: delivery_interval <= cfg_data;
          REG_RENEW: renew_margin <= cfg_data;
          REG_EXPIRY: expiry_span <= cfg_data;
          REG_GRACE: grace_span <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // command word, scan state and result word
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q <= cmd;
      ph <= peer_high;
      pl <= peer_low;
      now_q <= now;
      th <= ticket_high;
      tl <= ticket_low;
      exp_q <= outbound_expiry;
      lim <= limit;
      idx <= '0;
      wp <= '0;
      n <= '0;
      last_seen <= 1'b0;
      in_hit <= 1'b0;
    end else begin
      if (state == S_NEXT) idx <= idx + CW'(1);
      if (wp_inc) wp <= wp + CW'(1);
      if (n_inc) n <= n + CW'(1);
      if (set_last_seen) last_seen <= 1'b1;
      if (set_in_hit) begin
        in_hit <= 1'b1;
        hit_time <= rd.time_val;
        hit_th <= rd.ticket_high;
        hit_tl <= rd.ticket_low;
      end
    end
    if (emit) begin
      status <= e_status;
      created <= e_created;
      expiry_time <= e_time;
      out_ticket_high <= e_th;
      out_ticket_low <= e_tl;
      last <= e_last;
      entries_used <= 5'(fill_next);
      resume <= !e_last;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(ENTRIES)) else $error("fill count above table size");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while a word is pending");

  a_idle_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(fill)) else $error("fill changed while idle");

endmodule
